// ----- sv/apm_pkg.sv -----
// apm_pkg: shared constants, register codes and the per-channel state entry
// for the audio block peak/RMS/clip meter. No dependencies.
`timescale 1ns / 1ps

package apm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int MAX_FRAMES   = 4096;

    localparam int SAMPLE_W = 24;
    localparam int CH_W     = 3;
    localparam int MAG_W    = 24;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 58;
    localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int CHN_W    = 4;
    localparam int ADDR_W   = $clog2(NUM_CHANNELS);
    localparam int ROOT_W   = SUM_W / 2;
    localparam int SQREM_W  = ROOT_W + 3;
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEVEL = 2'd0,
        REG_CLIP_RUN   = 2'd1,
        REG_CHANNELS   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MAG_W-1:0] peak;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] frames;
        logic [CNT_W-1:0] head;
        logic             head_open;
        logic [CNT_W-1:0] tail;
        logic             clip;
    } entry_t;

    localparam entry_t ENTRY_CLEAR = '{
        peak: '0, sum: '0, frames: '0, head: '0,
        head_open: 1'b1, tail: '0, clip: 1'b0
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        logic [CNT_W-1:0] r;
        if (x < CNT_W'(MAX_FRAMES))
            r = x + 1'b1;
        else
            r = CNT_W'(MAX_FRAMES);
        return r;
    endfunction

endpackage

// ----- sv/apm_if.sv -----
// Channel interfaces for the meter: sample input, result output, config write.
// Depends on apm_pkg.
`timescale 1ns / 1ps

interface apm_sample_if;
    logic                          valid;
    logic                          ready;
    logic signed [apm_pkg::SAMPLE_W-1:0] sample;
    logic [apm_pkg::CH_W-1:0]      channel;
    logic                          last_in_block;

    modport source (output valid, sample, channel, last_in_block, input ready);
    modport sink   (input valid, sample, channel, last_in_block, output ready);
endinterface

interface apm_result_if;
    logic                          valid;
    logic                          ready;
    logic [apm_pkg::CH_W-1:0]      out_channel;
    logic [apm_pkg::MAG_W-1:0]     peak;
    logic [apm_pkg::MAG_W-1:0]     rms;
    logic [apm_pkg::CNT_W-1:0]     head_run;
    logic [apm_pkg::CNT_W-1:0]     tail_run;
    logic                          clipped;
    logic [apm_pkg::CNT_W-1:0]     frames;

    modport source (output valid, out_channel, peak, rms, head_run, tail_run,
                    clipped, frames, input ready);
    modport sink   (input valid, out_channel, peak, rms, head_run, tail_run,
                    clipped, frames, output ready);
endinterface

interface apm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [apm_pkg::CFG_IDX_W-1:0]  index;
    logic [apm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/audio_block_peak_rms_clip_core.sv -----
// Top level of the per-channel block peak/RMS/clip meter.
// Depends on apm_pkg, apm_if, apm_ram and apm_root.
`timescale 1ns / 1ps
//
//  channel   dir  modport  payload
//  samples   in   sink     sample, channel, last_in_block
//  results   out  source   out_channel, peak, rms, head_run, tail_run,
//                          clipped, frames
//  cfg       in   sink     index, data (always ready)
//
//  A sample transaction steps through accept with state RAM read, square,
//  then update and write back. A sample on an unmetered channel is taken
//  and dropped. A last-in-block sample adds the divide and the square root
//  in apm_root: the result register loads once the root is done and no
//  earlier result waits in it, and the next sample is taken after that load.
//  Reset is asynchronous; all channel entries read as cleared after reset
//  through per-entry valid flops, so no clearing pass is needed.
//  Results sit in an output register; a new sample may be accepted while a
//  result waits, and the next result waits for the register to drain.

module audio_block_peak_rms_clip_core (
    input  logic        clk,
    input  logic        rst_n,
    apm_sample_if.sink  samples,
    apm_result_if.source results,
    apm_cfg_if.sink     cfg
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_UPD, S_ROOT} state_t;

    typedef struct packed {
        logic [apm_pkg::CH_W-1:0]  channel;
        logic [apm_pkg::MAG_W-1:0] peak;
        logic [apm_pkg::CNT_W-1:0] head;
        logic [apm_pkg::CNT_W-1:0] tail;
        logic                      clip;
        logic [apm_pkg::CNT_W-1:0] frames;
    } stats_t;

    // configuration
    logic [apm_pkg::MAG_W-1:0] clip_level_reg;
    logic [apm_pkg::CNT_W-1:0] clip_run_reg;
    logic [apm_pkg::CHN_W-1:0] channels_reg;

    // sequencer and item registers
    state_t                         state_reg, state_next;
    logic [apm_pkg::CH_W-1:0]       ch_reg, ch_next;
    logic                           last_reg, last_next;
    logic [apm_pkg::MAG_W-1:0]      mag_reg, mag_next;
    logic [apm_pkg::SQ_W-1:0]       sq_reg, sq_next;
    apm_pkg::entry_t                entry_reg, entry_next;
    logic [apm_pkg::NUM_CHANNELS-1:0] valid_bits_reg, valid_bits_next;
    stats_t                         stats_reg, stats_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    stats_t                         out_stats_reg, out_stats_next;
    logic [apm_pkg::MAG_W-1:0]      out_rms_reg, out_rms_next;

    // RAM and root unit hookup
    apm_pkg::entry_t                ram_rdata;
    apm_pkg::entry_t                upd;
    logic                           ram_we;
    logic                           ram_re;
    logic                           root_start;
    logic                           root_done;
    logic [apm_pkg::MAG_W-1:0]      root_value;

    logic                           in_accept;
    logic                           metered;
    logic [apm_pkg::MAG_W-1:0]      in_mag;
    logic [apm_pkg::SUM_W:0]        sum_wide;
    logic                           full_scale;
    logic [apm_pkg::CNT_W-1:0]      tail_inc;
    logic                           out_free;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_level_reg <= apm_pkg::MAG_W'(8388607);
            clip_run_reg   <= apm_pkg::CNT_W'(3);
            channels_reg   <= apm_pkg::CHN_W'(2);
        end
        else if (cfg.valid)
        begin
            case (apm_pkg::cfg_index_t'(cfg.index))
                apm_pkg::REG_CLIP_LEVEL: clip_level_reg <= cfg.data[apm_pkg::MAG_W-1:0];
                apm_pkg::REG_CLIP_RUN:   clip_run_reg   <= cfg.data[apm_pkg::CNT_W-1:0];
                apm_pkg::REG_CHANNELS:   channels_reg   <= cfg.data[apm_pkg::CHN_W-1:0];
                default: ;
            endcase
        end
    end

    assign samples.ready = (state_reg == S_IDLE);
    assign in_accept     = samples.valid && samples.ready;
    assign metered       = ({1'b0, samples.channel} < channels_reg) &&
                           ({1'b0, samples.channel} <
                            (apm_pkg::CH_W+1)'(apm_pkg::NUM_CHANNELS));

    // magnitude of Q1.23; the most negative code maps to 2^23
    assign in_mag = samples.sample[apm_pkg::SAMPLE_W-1] ?
                    apm_pkg::MAG_W'(-samples.sample) :
                    apm_pkg::MAG_W'(samples.sample);

    assign ram_re = in_accept && metered;

    // read-modify of the channel entry
    assign sum_wide   = {1'b0, entry_reg.sum} + (apm_pkg::SUM_W+1)'(sq_reg);
    assign full_scale = (mag_reg >= clip_level_reg);
    assign tail_inc   = apm_pkg::sat_inc(entry_reg.tail);

    always_comb
    begin
        upd = entry_reg;
        if (mag_reg > entry_reg.peak)
            upd.peak = mag_reg;
        if (entry_reg.frames < apm_pkg::CNT_W'(apm_pkg::MAX_FRAMES))
            upd.sum = sum_wide[apm_pkg::SUM_W] ? '1 : sum_wide[apm_pkg::SUM_W-1:0];
        upd.frames = apm_pkg::sat_inc(entry_reg.frames);
        if (full_scale)
        begin
            if (entry_reg.head_open)
                upd.head = apm_pkg::sat_inc(entry_reg.head);
            upd.tail = tail_inc;
            if (tail_inc > clip_run_reg)
                upd.clip = 1'b1;
        end
        else
        begin
            upd.head_open = 1'b0;
            upd.tail      = '0;
        end
    end

    assign ram_we     = (state_reg == S_UPD);
    assign root_start = (state_reg == S_UPD) && last_reg;
    assign out_free   = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        last_next       = last_reg;
        mag_next        = mag_reg;
        sq_next         = sq_reg;
        entry_next      = entry_reg;
        valid_bits_next = valid_bits_reg;
        stats_next      = stats_reg;
        out_valid_next  = out_valid_reg;
        out_stats_next  = out_stats_reg;
        out_rms_next    = out_rms_reg;

        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (ram_re)
                begin
                    ch_next    = samples.channel;
                    last_next  = samples.last_in_block;
                    mag_next   = in_mag;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                sq_next = apm_pkg::SQ_W'(mag_reg * mag_reg);
                // an entry never written since reset or last report is clear
                entry_next = valid_bits_reg[ch_reg[apm_pkg::ADDR_W-1:0]] ?
                             ram_rdata : apm_pkg::ENTRY_CLEAR;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                valid_bits_next[ch_reg[apm_pkg::ADDR_W-1:0]] = !last_reg;
                stats_next = '{channel: ch_reg, peak: upd.peak, head: upd.head,
                               tail: upd.tail, clip: upd.clip, frames: upd.frames};
                state_next = last_reg ? S_ROOT : S_IDLE;
            end
            S_ROOT:
            begin
                if (root_done && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stats_next = stats_reg;
                    out_rms_next   = root_value;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_bits_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_bits_reg <= valid_bits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        last_reg      <= last_next;
        mag_reg       <= mag_next;
        sq_reg        <= sq_next;
        entry_reg     <= entry_next;
        stats_reg     <= stats_next;
        out_stats_reg <= out_stats_next;
        out_rms_reg   <= out_rms_next;
    end

    apm_ram #(
        .WIDTH ($bits(apm_pkg::entry_t)),
        .DEPTH (apm_pkg::NUM_CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_reg[apm_pkg::ADDR_W-1:0]),
        .wdata (upd),
        .re    (ram_re),
        .raddr (samples.channel[apm_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    apm_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (root_start),
        .sum    (upd.sum),
        .frames (upd.frames),
        .done   (root_done),
        .root   (root_value)
    );

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_stats_reg.channel;
    assign results.peak        = out_stats_reg.peak;
    assign results.rms         = out_rms_reg;
    assign results.head_run    = out_stats_reg.head;
    assign results.tail_run    = out_stats_reg.tail;
    assign results.clipped     = out_stats_reg.clip;
    assign results.frames      = out_stats_reg.frames;

endmodule

// ----- sv/apm_ram.sv -----
// apm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module apm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ----- sv/apm_root.sv -----
// apm_root: floor(sqrt(floor(sum / frames))), restoring divide one bit a
// cycle, then digit-by-digit square root one bit a cycle. Depends on apm_pkg.
`timescale 1ns / 1ps

module apm_root (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [apm_pkg::SUM_W-1:0]    sum,
    input  logic [apm_pkg::CNT_W-1:0]    frames,
    output logic                         done,
    output logic [apm_pkg::MAG_W-1:0]    root
);

    typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT, R_DONE} rstate_t;

    rstate_t                        state_reg, state_next;
    logic [apm_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [apm_pkg::CNT_W-1:0]      div_reg, div_next;
    logic [apm_pkg::CNT_W-1:0]      drem_reg, drem_next;
    logic [apm_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [apm_pkg::SQREM_W-1:0]    srem_reg, srem_next;
    logic [apm_pkg::ROOT_W-1:0]     root_reg, root_next;

    logic [apm_pkg::CNT_W:0]        drem_sh;
    logic [apm_pkg::SQREM_W+1:0]    srem_sh;
    logic [apm_pkg::SQREM_W+1:0]    trial;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        div_next   = div_reg;
        drem_next  = drem_reg;
        quo_next   = quo_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        drem_sh    = {drem_reg, quo_reg[apm_pkg::SUM_W-1]};
        srem_sh    = {srem_reg, quo_reg[apm_pkg::SUM_W-1 -: 2]};
        trial      = (apm_pkg::SQREM_W+2)'({root_reg, 2'b01});

        case (state_reg)
            R_IDLE, R_DONE:
            begin
                if (start)
                begin
                    state_next = R_DIV;
                    step_next  = apm_pkg::STEP_W'(apm_pkg::SUM_W - 1);
                    div_next   = frames;
                    drem_next  = '0;
                    quo_next   = sum;
                end
            end
            R_DIV:
            begin
                if (drem_sh >= {1'b0, div_reg})
                begin
                    drem_next = apm_pkg::CNT_W'(drem_sh - {1'b0, div_reg});
                    quo_next  = {quo_reg[apm_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_sh[apm_pkg::CNT_W-1:0];
                    quo_next  = {quo_reg[apm_pkg::SUM_W-2:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    state_next = R_SQRT;
                    step_next  = apm_pkg::STEP_W'(apm_pkg::ROOT_W - 1);
                    srem_next  = '0;
                    root_next  = '0;
                end
                else
                    step_next = step_reg - 1'b1;
            end
            R_SQRT:
            begin
                // quotient is consumed two bits at a time from the top
                quo_next = {quo_reg[apm_pkg::SUM_W-3:0], 2'b00};
                if (srem_sh >= trial)
                begin
                    srem_next = apm_pkg::SQREM_W'(srem_sh - trial);
                    root_next = {root_reg[apm_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh[apm_pkg::SQREM_W-1:0];
                    root_next = {root_reg[apm_pkg::ROOT_W-2:0], 1'b0};
                end
                if (step_reg == '0)
                    state_next = R_DONE;
                else
                    step_next = step_reg - 1'b1;
            end
            default:
                state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        drem_reg <= drem_next;
        quo_reg  <= quo_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done = (state_reg == R_DONE);
    assign root = root_reg[apm_pkg::MAG_W-1:0];

endmodule

// ----- dv/apm_tb_if.sv -----
// Testbench-side note: the channel interfaces come from the RTL (sv/apm_if.sv).
// This file holds the shared result record used by the meter testbench.
// Depends on apm_pkg.
`timescale 1ns / 1ps

package apm_tb_pkg;

    typedef struct packed {
        logic [apm_pkg::CH_W-1:0]  out_channel;
        logic [apm_pkg::MAG_W-1:0] peak;
        logic [apm_pkg::MAG_W-1:0] rms;
        logic [apm_pkg::CNT_W-1:0] head_run;
        logic [apm_pkg::CNT_W-1:0] tail_run;
        logic                      clipped;
        logic [apm_pkg::CNT_W-1:0] frames;
    } block_stats_t;

endpackage

// ----- dv/audio_block_peak_rms_clip_core_tb.sv -----
// Self-checking testbench for audio_block_peak_rms_clip_core: directed table,
// then random sample blocks, checked against an in-bench block meter model.
// Depends on apm_pkg, apm_tb_pkg and the RTL interfaces in apm_if.
`timescale 1ns / 1ps

module audio_block_peak_rms_clip_core_tb;
    import apm_pkg::*;
    import apm_tb_pkg::*;

    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};
    localparam int SETTLE_CYCLES = 200;   // wait after drain, covers divide + root

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    apm_sample_if smp ();
    apm_result_if res ();
    apm_cfg_if    cfg ();

    audio_block_peak_rms_clip_core dut (
        .clk(clk), .rst_n(rst_n), .samples(smp), .results(res), .cfg(cfg)
    );

    // ------------------------------------------------------------------
    // Meter model state: configuration and one entry per channel
    // ------------------------------------------------------------------
    logic [23:0]       lvl_m;
    logic [12:0]       run_m;
    logic [3:0]        nch_m;
    logic [MAG_W-1:0]  m_peak [NUM_CHANNELS];
    logic [SUM_W-1:0]  m_sum  [NUM_CHANNELS];
    logic [CNT_W-1:0]  m_frm  [NUM_CHANNELS];
    logic [CNT_W-1:0]  m_head [NUM_CHANNELS];
    logic              m_hopen[NUM_CHANNELS];
    logic [CNT_W-1:0]  m_tail [NUM_CHANNELS];
    logic              m_clip [NUM_CHANNELS];

    block_stats_t stats_due[$];   // expected block reports, oldest first
    int  mismatches = 0;
    int  idle_in_pct = 0;         // sender idle chance, percent
    int  idle_out_pct = 0;        // receiver idle chance, percent
    bit  hold_results = 1'b0;     // long receiver hold-off
    bit  stim_done = 1'b0;

    function automatic logic [CNT_W-1:0] cnt_up(logic [CNT_W-1:0] x);
        return (x < CNT_W'(MAX_FRAMES)) ? x + 1'b1 : CNT_W'(MAX_FRAMES);
    endfunction

    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic void clear_entry(int c);
        m_peak[c] = '0; m_sum[c] = '0; m_frm[c] = '0; m_head[c] = '0;
        m_hopen[c] = 1'b1; m_tail[c] = '0; m_clip[c] = 1'b0;
    endfunction

    // Account one sample; returns 1 and the block report on block end.
    function automatic bit meter_sample(logic [23:0] s, logic [2:0] ch, logic lst,
                                        output block_stats_t st);
        logic [24:0] mag;
        logic [63:0] sum;
        logic [31:0] root;
        int c;
        c = ch;
        st = '0;
        if (ch >= nch_m) return 0;
        mag = s[23] ? (25'h1000000 - {1'b0, s}) : {1'b0, s};
        if (mag > m_peak[c]) m_peak[c] = mag[23:0];
        if (m_frm[c] < CNT_W'(MAX_FRAMES))
        begin
            sum = 64'(m_sum[c]) + 64'(mag) * 64'(mag);
            m_sum[c] = (sum > 64'(SUM_SAT)) ? SUM_SAT : sum[SUM_W-1:0];
        end
        m_frm[c] = cnt_up(m_frm[c]);
        if (mag >= {1'b0, lvl_m})
        begin
            if (m_hopen[c]) m_head[c] = cnt_up(m_head[c]);
            m_tail[c] = cnt_up(m_tail[c]);
            if (m_tail[c] > run_m) m_clip[c] = 1'b1;
        end
        else
        begin
            m_hopen[c] = 1'b0;
            m_tail[c] = '0;
        end
        if (!lst) return 0;
        root = floor_root(64'(m_sum[c]) / 64'(m_frm[c]));
        st.out_channel = ch;
        st.peak = m_peak[c];
        st.rms = root[23:0];
        st.head_run = m_head[c];
        st.tail_run = m_tail[c];
        st.clipped = m_clip[c];
        st.frames = m_frm[c];
        clear_entry(c);
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    initial
    begin
        smp.valid = 1'b0; smp.sample = '0; smp.channel = '0; smp.last_in_block = 1'b0;
        cfg.valid = 1'b0; cfg.index = REG_CLIP_LEVEL; cfg.data = '0;
        res.ready = 1'b0;
    end

    // One sample transaction; model is updated at the accepting edge.
    // Valid stays high after acceptance until the next idle or drain.
    task automatic send_sample(logic [23:0] s, logic [2:0] ch, logic lst,
                               bit has_fixed, block_stats_t fixed);
        block_stats_t st;
        while ($urandom_range(99) < idle_in_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid <= 1'b1;
        smp.sample <= s;
        smp.channel <= ch;
        smp.last_in_block <= lst;
        do @(posedge clk); while (!smp.ready);
        if (meter_sample(s, ch, lst, st))
        begin
            // typed-in row value must agree with the model as well
            if (has_fixed && st != fixed)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees: exp %h model %h", fixed, st);
            end
            stats_due.push_back(has_fixed ? fixed : st);
        end
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_CLIP_LEVEL: lvl_m = val;
            REG_CLIP_RUN:   run_m = val[12:0];
            REG_CHANNELS:   nch_m = val[3:0];
            default: ;
        endcase
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= !hold_results && ($urandom_range(99) >= idle_out_pct);
    end

    // Result checker: compare each report with the oldest expectation.
    always @(posedge clk)
    begin
        block_stats_t got;
        block_stats_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.out_channel, res.peak, res.rms, res.head_run,
                    res.tail_run, res.clipped, res.frames};
            if (stats_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
            end
            else
            begin
                want = stats_due.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        logic [23:0]  s;
        logic [2:0]   ch;
        logic         lst;
        bit           fixed;
        block_stats_t st;
    } row_t;

    row_t rows[$];

    task automatic add_row(logic [23:0] s, logic [2:0] ch, logic lst);
        rows.push_back('{s, ch, lst, 1'b0, '0});
    endtask

    task automatic add_fixed(logic [23:0] s, logic [2:0] ch, block_stats_t st);
        rows.push_back('{s, ch, 1'b1, 1'b1, st});
    endtask

    // Random block of one channel; mostly well-formed, some full-scale runs.
    task automatic random_block(int len);
        logic [2:0] ch;
        logic [23:0] s;
        int mode;
        ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 0))
                                      : 3'($urandom_range(nch_m == 0 ? 0 : nch_m - 1));
        for (int i = 0; i < len; i++)
        begin
            mode = $urandom_range(5);
            case (mode)
                0: s = 24'h7FFFFF;
                1: s = 24'h800000;
                2: s = lvl_m + 24'($urandom_range(3));
                3: s = -lvl_m;
                default: s = 24'($urandom);
            endcase
            send_sample(s, ch, i == len - 1, 1'b0, '0);
        end
    endtask

    initial
    begin
        int sent;
        int len;
        lvl_m = 24'd8388607; run_m = 13'd3; nch_m = 4'd2;
        for (int c = 0; c < NUM_CHANNELS; c++) clear_entry(c);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: single zero sample -> all-zero stats, one frame
        add_fixed(24'h000000, 3'd0, '{3'd0, 24'd0, 24'd0, 13'd0, 13'd0, 1'b0, 13'd1});
        // Most negative sample: magnitude 2^23, full scale
        add_fixed(24'h800000, 3'd1,
                  '{3'd1, 24'h800000, 24'h800000, 13'd1, 13'd1, 1'b0, 13'd1});
        // Unmetered channel, also with last set
        add_row(24'h123456, 3'd5, 1'b1);
        add_row(24'h7FFFFF, 3'd7, 1'b0);
        // Run of five full-scale samples exceeds clip_run 3
        for (int i = 0; i < 4; i++) add_row(24'h7FFFFF, 3'd0, 1'b0);
        add_fixed(24'h7FFFFF, 3'd0,
                  '{3'd0, 24'h7FFFFF, 24'h7FFFFF, 13'd5, 13'd5, 1'b1, 13'd5});
        // Head run broken, tail resumes
        add_row(24'h800001, 3'd1, 1'b0);
        add_row(24'h000001, 3'd1, 1'b0);
        add_row(24'h7FFFFF, 3'd1, 1'b1);
        foreach (rows[i])
            send_sample(rows[i].s, rows[i].ch, rows[i].lst, rows[i].fixed, rows[i].st);
        wait_drained();

        // Zero clip level, all channels, zero clip_run
        write_reg(REG_CLIP_LEVEL, 24'd0);
        write_reg(REG_CLIP_RUN, 24'd0);
        write_reg(REG_CHANNELS, 24'd8);
        for (int c = 0; c < 8; c++)
            send_sample(24'(c * 1000), 3'(c), 1'b1, 1'b0, '0);
        wait_drained();
        // Zero channels: nothing metered
        write_reg(REG_CHANNELS, 24'd0);
        send_sample(24'h400000, 3'd0, 1'b1, 1'b0, '0);
        wait_drained();

        // Random phases: sender idles 9 / receiver 88, then swapped, then none
        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_in_pct = (ph == 0) ? 9 : (ph == 1) ? 88 : 0;
            idle_out_pct = (ph == 0) ? 88 : (ph == 1) ? 9 : 0;
            write_reg(REG_CLIP_LEVEL, (ph == 2) ? 24'h7FFFFF : 24'($urandom_range(8388608)));
            write_reg(REG_CLIP_RUN, 24'($urandom_range(6)));
            write_reg(REG_CHANNELS, 24'($urandom_range(8, 1)));
            if (ph == 2)
            begin
                // long receiver hold-off while samples keep coming
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_results = 1'b0;
                    end
                join_none
            end
            while (sent < (ph + 1) * 643)
            begin
                len = $urandom_range(6, 1);
                random_block(len);
                sent += len;
            end
            wait_drained();   // sender pauses until every result is in
        end
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        if (mismatches == 0 && stats_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #80ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
